>>> rtl/core/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types and constants of the RGB 3x3 box blur unit.
// ----------------------------------------------------------------------------
package rbb_pkg;

  // packed pixel: red in the low byte, then green, then blue
  typedef logic [23:0] rbb_pix_t;

  // configuration register indexes
  localparam logic CFG_IDX_W = 1'b1;
  typedef enum logic [0:0] {
    REG_LINE_LENGTH = 1'b0,
    REG_LINE_COUNT  = 1'b1
  } rbb_reg_t;

  localparam int CFG_DATA_W = 13;
  localparam int LEN_REG_W  = 11;
  localparam int CNT_REG_W  = 13;
  localparam int LINE_W     = 12;
  localparam int POS_OUT_W  = 10;
  localparam int NUM_W      = 13;
  localparam int SUM_W      = 12;

  // floor(s/9) = (s * 7282) >> 16 for every s up to 9*255
  localparam int          DIV_SHIFT = 16;
  localparam logic [13:0] RECIP9    = 14'd7282;
  localparam int          PROD_W    = SUM_W + 14;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  // per-item control that follows a pixel down the window pipeline
  typedef struct packed {
    logic                 emit;
    logic                 up;
    logic                 down;
    logic                 left;
    logic                 right;
    logic                 last;
    logic [LINE_W-1:0]    cl;
    logic [POS_OUT_W-1:0] cp;
  } rbb_meta_t;

  // one finished result word
  typedef struct packed {
    logic                 last;
    logic [POS_OUT_W-1:0] pos_in_line;
    logic [LINE_W-1:0]    line_index;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
  } rbb_res_t;

endpackage

>>> rtl/core/rbb_line_mem.sv
// ----------------------------------------------------------------------------
// rbb_line_mem
// Two-line store in one memory; each entry holds the older and newer line at
// one position. Read-modify-write per pixel with a one-entry write bypass.
// ----------------------------------------------------------------------------
module rbb_line_mem #(
  parameter int MAX_LINE = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [$clog2(MAX_LINE)-1:0] rd_addr,
  input  logic                        wr_en,
  input  logic [$clog2(MAX_LINE)-1:0] wr_addr,
  input  rbb_pkg::rbb_pix_t           wr_col2,
  output rbb_pkg::rbb_pix_t           col0,
  output rbb_pkg::rbb_pix_t           col1
);

  logic [47:0] mem [MAX_LINE];
  logic [47:0] mem_q;
  logic [47:0] fwd_data_r;
  logic        fwd_r;
  logic [47:0] rd_word;
  logic [47:0] wr_word;

  // pick bypassed data when the previous write hit the same entry
  assign rd_word = fwd_r ? fwd_data_r : mem_q;
  assign col0    = rd_word[23:0];
  assign col1    = rd_word[47:24];
  assign wr_word = {wr_col2, col1};

  // memory port: write back shifted lines, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      mem_q      <= mem[rd_addr];
      fwd_data_r <= wr_word;
    end
  end

  // bypass flag: read and write of the same entry at one edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (rd_addr == wr_addr);
    end
  end

endmodule

>>> rtl/core/rbb_window_sum.sv
// ----------------------------------------------------------------------------
// rbb_window_sum
// 3x3 window registers, masked channel sums and the divide by nine.
// ----------------------------------------------------------------------------
module rbb_window_sum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic               shift_en,
  input  rbb_pkg::rbb_pix_t  col_top,
  input  rbb_pkg::rbb_pix_t  col_mid,
  input  rbb_pkg::rbb_pix_t  col_bot,
  input  rbb_pkg::rbb_meta_t meta_in,
  output logic               res_valid,
  output rbb_pkg::rbb_res_t  res,
  output logic [1:0]         pend
);

  rbb_pkg::rbb_pix_t  win_r [3][3];
  logic               zf_r;
  logic               s2_v_r;
  rbb_pkg::rbb_meta_t s2_meta_r;
  logic               s3_v_r;
  rbb_pkg::rbb_meta_t s3_meta_r;
  logic [rbb_pkg::SUM_W-1:0] s3_sum_r [3];
  logic [rbb_pkg::SUM_W-1:0] sum_nxt [3];
  logic [7:0]                quo [3];

  // window shift; older columns read as zero after a frame restart
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= zf_r ? '0 : win_r[r][1];
        win_r[r][1] <= zf_r ? '0 : win_r[r][2];
      end
      win_r[0][2] <= col_top;
      win_r[1][2] <= col_mid;
      win_r[2][2] <= col_bot;
    end
  end

  // restart flag and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zf_r   <= 1'b1;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (restart) begin
        zf_r <= 1'b1;
      end else if (shift_en) begin
        zf_r <= meta_in.emit && meta_in.last;
      end
      s2_v_r <= shift_en && meta_in.emit;
      s3_v_r <= s2_v_r;
    end
  end

  // masked sums over the window
  always_comb begin
    logic [2:0] row_en;
    logic [2:0] col_en;
    row_en = {s2_meta_r.down, 1'b1, s2_meta_r.up};
    col_en = {s2_meta_r.right, 1'b1, s2_meta_r.left};
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (row_en[r] && col_en[c]) begin
            sum_nxt[ch] = sum_nxt[ch] + rbb_pkg::SUM_W'(win_r[r][c][8*ch +: 8]);
          end
        end
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    s2_meta_r <= meta_in;
    s3_meta_r <= s2_meta_r;
    for (int ch = 0; ch < 3; ch++) begin
      s3_sum_r[ch] <= sum_nxt[ch];
    end
  end

  // divide by nine through the reciprocal
  always_comb begin
    logic [rbb_pkg::PROD_W-1:0] prod;
    for (int ch = 0; ch < 3; ch++) begin
      prod    = rbb_pkg::PROD_W'(s3_sum_r[ch]) * rbb_pkg::PROD_W'(rbb_pkg::RECIP9);
      quo[ch] = prod[rbb_pkg::DIV_SHIFT +: 8];
    end
  end

  assign res_valid       = s3_v_r;
  assign res.red         = quo[0];
  assign res.green       = quo[1];
  assign res.blue        = quo[2];
  assign res.line_index  = s3_meta_r.cl;
  assign res.pos_in_line = s3_meta_r.cp;
  assign res.last        = s3_meta_r.last;
  assign pend            = {1'b0, s2_v_r} + {1'b0, s3_v_r};

endmodule

>>> rtl/core/rbb_out_fifo.sv
// ----------------------------------------------------------------------------
// rbb_out_fifo
// Small result queue between the window pipeline and the output stream.
// ----------------------------------------------------------------------------
module rbb_out_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  rbb_pkg::rbb_res_t            wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rbb_pkg::rbb_res_t            out_data,
  output logic [rbb_pkg::FIFO_CW-1:0]  count
);

  rbb_pkg::rbb_res_t               q_mem [rbb_pkg::FIFO_DEPTH];
  logic [rbb_pkg::FIFO_AW-1:0]     wr_ptr_r;
  logic [rbb_pkg::FIFO_AW-1:0]     rd_ptr_r;
  logic [rbb_pkg::FIFO_CW-1:0]     cnt_r;
  logic                            pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = q_mem[rd_ptr_r];
  assign count     = cnt_r;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + rbb_pkg::FIFO_CW'(wr_en) - rbb_pkg::FIFO_CW'(pop);
    end
  end

endmodule

>>> rtl/core/rgb_box_blur_3x3_unit.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_unit
// 3x3 box blur over an RGB pixel stream, two line buffers in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per pixel in storage order; in_tuser high marks a drain
//           tick that carries no pixel. Drain ticks push out the last
//           line_length+1 results after the final pixel of a frame.
//   out_* : blurred pixel with its line and position; out_tlast marks the
//           final pixel of the frame.
//   cfg_* : line_length (index 0) and line_count (index 1); any write
//           restarts the frame. Write only while the block is idle.
// Throughput: one input word per clock while in_tready is high. The only loop
//   is the line memory read-modify-write, which a write bypass closes.
// Results: a result belongs to the word line_length+1 words earlier; once that
//   word is accepted it passes the first stage, the window and sum registers
//   and the queue write, and shows on out_tvalid right after that write.
// Reset: counters cleared, geometry back to 1024 x 1024; the line memory is
//   not cleared and needs no sweep.
// Stall: up to 8 results wait in the output queue; in_tready drops when the
//   queue plus the results in flight reach 8.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_unit #(
  parameter int MAX_LINE = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // red_in, green_in, blue_in
  input  logic                            in_tuser,   // action
  // output stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,  // red_out, green_out, blue_out,
                                                      // line_index, pos_in_line, pad
  output logic                            out_tlast,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [0:0]                      cfg_addr,
  input  logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int POS_W = $clog2(MAX_LINE);

  // clamp line_length to 1..MAX_LINE, kept as length minus one
  function automatic logic [POS_W-1:0] len_m1_of(
    input logic [rbb_pkg::LEN_REG_W-1:0] v
  );
    if (v == '0) begin
      return '0;
    end else if (32'(v) > 32'(MAX_LINE)) begin
      return POS_W'(MAX_LINE - 1);
    end else begin
      return POS_W'(v - 1'b1);
    end
  endfunction

  // clamp line_count to 1..4096, kept as count minus one
  function automatic logic [rbb_pkg::LINE_W-1:0] cnt_m1_of(
    input logic [rbb_pkg::CNT_REG_W-1:0] v
  );
    if (v == '0) begin
      return '0;
    end else if (v[rbb_pkg::CNT_REG_W-1] && (v[rbb_pkg::CNT_REG_W-2:0] != '0)) begin
      return '1;
    end else begin
      return rbb_pkg::LINE_W'(v - 1'b1);
    end
  endfunction

  logic [POS_W-1:0]              len_m1_r;
  logic [rbb_pkg::LINE_W-1:0]    cnt_m1_r;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [rbb_pkg::NUM_W-1:0]     num_r, num_nxt;

  logic                          accept;
  logic                          feeding;
  logic                          active;
  logic                          pos_zero;
  logic                          wrap;
  logic [rbb_pkg::NUM_W-1:0]     cl_full;
  logic                          cl_ok;
  logic [POS_W-1:0]              cp;
  rbb_pkg::rbb_meta_t            meta_nxt;
  rbb_pkg::rbb_pix_t             col2_nxt;

  logic                          s1_act_r;
  logic [POS_W-1:0]              s1_addr_r;
  rbb_pkg::rbb_pix_t             s1_col2_r;
  rbb_pkg::rbb_meta_t            s1_meta_r;

  rbb_pkg::rbb_pix_t             col0;
  rbb_pkg::rbb_pix_t             col1;
  logic                          res_valid;
  rbb_pkg::rbb_res_t             res;
  rbb_pkg::rbb_res_t             out_res;
  logic [1:0]                    pend;
  logic [rbb_pkg::FIFO_CW-1:0]   fifo_cnt;
  logic [rbb_pkg::FIFO_CW:0]     credit_used;

  // credit check against the result queue
  assign credit_used = (rbb_pkg::FIFO_CW+1)'(fifo_cnt)
                     + (rbb_pkg::FIFO_CW+1)'(s1_act_r && s1_meta_r.emit)
                     + (rbb_pkg::FIFO_CW+1)'(pend);
  assign in_tready   = credit_used < (rbb_pkg::FIFO_CW+1)'(rbb_pkg::FIFO_DEPTH);
  assign accept      = in_tvalid && in_tready;

  // position decode of the incoming word and of the pixel it completes
  always_comb begin
    pos_zero = (pos_r == '0);
    feeding  = num_r <= {1'b0, cnt_m1_r};
    active   = !(in_tuser && feeding);
    col2_nxt = feeding ? in_tdata : '0;
    cl_full  = num_r - (pos_zero ? rbb_pkg::NUM_W'(2) : rbb_pkg::NUM_W'(1));
    cl_ok    = pos_zero ? (num_r >= rbb_pkg::NUM_W'(2)) : (num_r != '0);
    cp       = pos_zero ? len_m1_r : pos_r - 1'b1;

    meta_nxt.emit  = cl_ok && (cl_full <= {1'b0, cnt_m1_r});
    meta_nxt.cl    = cl_full[rbb_pkg::LINE_W-1:0];
    meta_nxt.cp    = rbb_pkg::POS_OUT_W'(cp);
    meta_nxt.up    = meta_nxt.cl != '0;
    meta_nxt.down  = meta_nxt.cl != cnt_m1_r;
    meta_nxt.left  = cp != '0;
    meta_nxt.right = cp != len_m1_r;
    meta_nxt.last  = (meta_nxt.cl == cnt_m1_r) && (cp == len_m1_r);

    wrap    = (pos_r == len_m1_r);
    pos_nxt = wrap ? '0 : pos_r + 1'b1;
    num_nxt = num_r + rbb_pkg::NUM_W'(wrap);
    if (meta_nxt.emit && meta_nxt.last) begin
      pos_nxt = '0;
      num_nxt = '0;
    end
  end

  // geometry registers and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_m1_r <= len_m1_of(rbb_pkg::LEN_REG_W'(1024));
      cnt_m1_r <= cnt_m1_of(rbb_pkg::CNT_REG_W'(1024));
      pos_r    <= '0;
      num_r    <= '0;
      s1_act_r <= 1'b0;
    end else begin
      s1_act_r <= accept && active && !cfg_wr_en;
      if (cfg_wr_en) begin
        case (rbb_pkg::rbb_reg_t'(cfg_addr))
          rbb_pkg::REG_LINE_LENGTH: begin
            len_m1_r <= len_m1_of(cfg_wdata[rbb_pkg::LEN_REG_W-1:0]);
          end
          rbb_pkg::REG_LINE_COUNT: begin
            cnt_m1_r <= cnt_m1_of(cfg_wdata);
          end
          default: begin
          end
        endcase
        pos_r <= '0;
        num_r <= '0;
      end else if (accept && active) begin
        pos_r <= pos_nxt;
        num_r <= num_nxt;
      end
    end
  end

  // first pipeline stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r <= pos_r;
      s1_col2_r <= col2_nxt;
      s1_meta_r <= meta_nxt;
    end
  end

  rbb_line_mem #(
    .MAX_LINE (MAX_LINE)
  ) u_line_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && active),
    .rd_addr (pos_r),
    .wr_en   (s1_act_r),
    .wr_addr (s1_addr_r),
    .wr_col2 (s1_col2_r),
    .col0    (col0),
    .col1    (col1)
  );

  rbb_window_sum u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_wr_en),
    .shift_en  (s1_act_r),
    .col_top   (col0),
    .col_mid   (col1),
    .col_bot   (s1_col2_r),
    .meta_in   (s1_meta_r),
    .res_valid (res_valid),
    .res       (res),
    .pend      (pend)
  );

  rbb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res_valid),
    .wr_data   (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res),
    .count     (fifo_cnt)
  );

  // output word packing
  assign out_tdata = {2'b00, out_res.pos_in_line, out_res.line_index,
                      out_res.blue, out_res.green, out_res.red};
  assign out_tlast = out_res.last;

endmodule
